>>> src/mllpq_pkg.sv
`timescale 1ns / 1ps
package mllpq_pkg;

	// Default sizing of the queue
	localparam int LEVELS_DEF      = 4;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int WORD_BITS_DEF   = 32;

	// Fixed widths of the word fields
	localparam int DATA_W  = 32;
	localparam int LEVEL_W = 4;
	localparam int WIDE_W  = 64;

	// Request codes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic commit_push;
		logic issue_pop;
		logic load_push;
		logic load_pop;
	} mllpq_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic req_pop;
	} mllpq_sts_t;

endpackage

>>> src/multi_level_lifo_priority_queue_unit.sv
`timescale 1ns / 1ps
// A push word loads its result in the EXEC state; a pop word issues its RAM read in EXEC and
// loads its result in READ. Pushes run at one word per cycle while the output is not stalled;
// pops also pass READ for the registered read of the word RAM that follows the priority encode.
// Reset clears the controller, the output valid and all fill counters at once; the word RAM
// is not cleared, as only slots below a level's fill are ever read.
module multi_level_lifo_priority_queue_unit
	import mllpq_pkg::*;
#(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [LEVEL_W-1:0] priority_req,
	input  logic [DATA_W-1:0]  data_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DATA_W-1:0]  data_out,
	output logic               found,
	output logic [LEVEL_W-1:0] served_level,
	output logic               dropped,
	output logic               now_empty
);

	mllpq_cmd_t cmd;
	mllpq_sts_t sts;

	// Sequence each word
	mllpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the stacks and form results
	mllpq_dp #(
		.LEVELS     (LEVELS),
		.LEVEL_DEPTH(LEVEL_DEPTH),
		.WORD_BITS  (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.priority_req(priority_req),
		.data_in     (data_in),
		.data_out    (data_out),
		.found       (found),
		.served_level(served_level),
		.dropped     (dropped),
		.now_empty   (now_empty)
	);

endmodule

>>> src/mllpq_ram.sv
`timescale 1ns / 1ps
module mllpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/mllpq_dp.sv
`timescale 1ns / 1ps
module mllpq_dp
	import mllpq_pkg::*;
#(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mllpq_cmd_t         cmd,
	output mllpq_sts_t         sts,
	input  logic               mode,
	input  logic [LEVEL_W-1:0] priority_req,
	input  logic [DATA_W-1:0]  data_in,
	output logic [DATA_W-1:0]  data_out,
	output logic               found,
	output logic [LEVEL_W-1:0] served_level,
	output logic               dropped,
	output logic               now_empty
);

	localparam int SLOTS  = LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
	localparam int TOT_W  = $clog2(SLOTS + 1);
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	// Held request word
	logic               req_mode_q;
	logic [LEVEL_W-1:0] req_level_q;
	logic [DATA_W-1:0]  req_data_q;

	// Fill counters
	logic [FILL_W-1:0] fill_q [LEVELS];
	logic [TOT_W-1:0]  total_q;

	// Pop bookkeeping between address issue and data return
	logic             pop_found_q;
	logic [LVL_W-1:0] pop_lvl_q;

	logic               level_ok;
	logic [FILL_W-1:0]  push_fill;
	logic               push_drop;
	logic               pop_any;
	logic [LVL_W-1:0]   pop_lvl;
	logic [FILL_W-1:0]  pop_fill;
	logic [ADDR_W-1:0]  push_addr;
	logic [ADDR_W-1:0]  pop_addr;
	logic [WIDE_W-1:0]  din_wide;
	logic [WIDE_W-1:0]  rd_wide;
	logic [WORD_BITS-1:0] rd_data;
	logic               do_push;
	logic               do_pop;

	assign sts.req_pop = (req_mode_q == MODE_POP);

	// Check the push target and fetch its fill
	always_comb begin
		level_ok  = ({1'b0, req_level_q} < (LEVEL_W + 1)'(LEVELS));
		push_fill = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (req_level_q == LEVEL_W'(l)) begin
				push_fill = fill_q[l];
			end
		end
		push_drop = !level_ok || (push_fill == FILL_W'(LEVEL_DEPTH));
	end

	// Find the lowest non-empty level
	always_comb begin
		pop_any  = 1'b0;
		pop_lvl  = '0;
		pop_fill = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (fill_q[l] != '0) begin
				pop_any  = 1'b1;
				pop_lvl  = LVL_W'(l);
				pop_fill = fill_q[l];
			end
		end
	end

	// Form slot addresses: level base plus stack position
	always_comb begin
		push_addr = ADDR_W'(LEVEL_DEPTH) * ADDR_W'(req_level_q) + ADDR_W'(push_fill);
		pop_addr  = ADDR_W'(LEVEL_DEPTH) * ADDR_W'(pop_lvl) + ADDR_W'(pop_fill - 1'b1);
	end

	assign do_push  = cmd.commit_push && !push_drop;
	assign do_pop   = cmd.issue_pop && pop_any;
	assign din_wide = WIDE_W'(req_data_q);
	assign rd_wide  = WIDE_W'(rd_data);

	mllpq_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(SLOTS)
	) u_store (
		.clk  (clk),
		.we   (do_push),
		.waddr(push_addr),
		.wdata(din_wide[WORD_BITS-1:0]),
		.re   (do_pop),
		.raddr(pop_addr),
		.rdata(rd_data)
	);

	// Capture the request word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_mode_q  <= mode;
			req_level_q <= priority_req;
			req_data_q  <= data_in;
		end
	end

	// Advance the fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				fill_q[l] <= '0;
			end
			total_q <= '0;
		end else if (do_push) begin
			for (int l = 0; l < LEVELS; l++) begin
				if (req_level_q == LEVEL_W'(l)) begin
					fill_q[l] <= fill_q[l] + 1'b1;
				end
			end
			total_q <= total_q + 1'b1;
		end else if (do_pop) begin
			for (int l = 0; l < LEVELS; l++) begin
				if (pop_lvl == LVL_W'(l)) begin
					fill_q[l] <= fill_q[l] - 1'b1;
				end
			end
			total_q <= total_q - 1'b1;
		end
	end

	// Hold the pop outcome until the word returns
	always_ff @(posedge clk) begin
		if (cmd.issue_pop) begin
			pop_found_q <= pop_any;
			pop_lvl_q   <= pop_lvl;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.load_push) begin
			data_out     <= '0;
			found        <= 1'b0;
			served_level <= '0;
			dropped      <= push_drop;
			now_empty    <= push_drop && (total_q == '0);
		end else if (cmd.load_pop) begin
			data_out     <= pop_found_q ? rd_wide[DATA_W-1:0] : '0;
			found        <= pop_found_q;
			served_level <= pop_found_q ? LEVEL_W'(pop_lvl_q) : '0;
			dropped      <= 1'b0;
			now_empty    <= (total_q == '0);
		end
	end

endmodule

>>> src/mllpq_ctrl.sv
`timescale 1ns / 1ps
module mllpq_ctrl
	import mllpq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  mllpq_sts_t sts,
	output mllpq_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   done;
	logic   accept;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Decide completion and issue commands
	always_comb begin
		cmd      = '0;
		done     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				done = 1'b0;
			end
			ST_EXEC: begin
				if (sts.req_pop) begin
					cmd.issue_pop = 1'b1;
				end else if (out_free) begin
					cmd.commit_push = 1'b1;
					cmd.load_push   = 1'b1;
					done            = 1'b1;
				end
			end
			ST_READ: begin
				if (out_free) begin
					cmd.load_pop = 1'b1;
					done         = 1'b1;
				end
			end
			default: begin
				done = 1'b0;
			end
		endcase
		in_stall    = !((state_q == ST_IDLE) || done);
		accept      = in_valid && !in_stall;
		cmd.capture = accept;
	end

	// Hold state and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_push || cmd.load_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (sts.req_pop) begin
						state_q <= ST_READ;
					end else if (done) begin
						state_q <= accept ? ST_EXEC : ST_IDLE;
					end
				end
				ST_READ: begin
					if (done) begin
						state_q <= accept ? ST_EXEC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> verif/tb_multi_level_lifo_priority_queue_unit.sv
`timescale 1ns / 1ps
module tb_multi_level_lifo_priority_queue_unit;
	import mllpq_pkg::*;

	localparam int LEVELS      = LEVELS_DEF;
	localparam int LEVEL_DEPTH = LEVEL_DEPTH_DEF;
	localparam logic [DATA_W-1:0] WORD_MASK = DATA_W'((65'd1 << WORD_BITS_DEF) - 65'd1);

	typedef struct packed {
		logic [DATA_W-1:0]  data;
		logic               found;
		logic [LEVEL_W-1:0] level;
		logic               dropped;
		logic               empty;
	} queue_result_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic               mode         = MODE_PUSH;
	logic [LEVEL_W-1:0] priority_req = '0;
	logic [DATA_W-1:0]  data_in      = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [DATA_W-1:0]  data_out;
	logic               found;
	logic [LEVEL_W-1:0] served_level;
	logic               dropped;
	logic               now_empty;

	// Shadow copy of the stacks
	logic [DATA_W-1:0] stack_words [LEVELS][LEVEL_DEPTH];
	int                level_count [LEVELS];
	int                words_held;

	queue_result_t pending_results[$];
	int            mismatch_count;
	bit            in_quiet;
	bit            out_quiet;
	int            stall_left;

	multi_level_lifo_priority_queue_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.priority_req (priority_req),
		.data_in      (data_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_out     (data_out),
		.found        (found),
		.served_level (served_level),
		.dropped      (dropped),
		.now_empty    (now_empty)
	);

	always #4 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// Work out the result of one accepted word and advance the shadow stacks
	task automatic predict_queue_op(input logic m, input logic [LEVEL_W-1:0] lvl,
			input logic [DATA_W-1:0] d);
		queue_result_t res;
		int lv;
		res = '0;
		if (m == MODE_PUSH) begin
			if (int'(lvl) >= LEVELS) begin
				res.dropped = 1'b1;
			end else if (level_count[lvl] >= LEVEL_DEPTH) begin
				res.dropped = 1'b1;
			end else begin
				stack_words[lvl][level_count[lvl]] = d & WORD_MASK;
				level_count[lvl]++;
				words_held++;
			end
		end else begin
			// serve the lowest-numbered level that holds anything
			for (lv = 0; lv < LEVELS && !res.found; lv++) begin
				if (level_count[lv] != 0) begin
					level_count[lv]--;
					res.data  = stack_words[lv][level_count[lv]];
					res.found = 1'b1;
					res.level = LEVEL_W'(lv);
					words_held--;
				end
			end
		end
		res.empty = (words_held == 0);
		pending_results = {pending_results, res};
	endtask

	// Drive one word, hold it until taken, then idle for a random gap, possibly none
	task automatic send_word(input logic m, input logic [LEVEL_W-1:0] lvl,
			input logic [DATA_W-1:0] d);
		int gap;
		@(negedge clk);
		in_valid     = 1'b1;
		mode         = m;
		priority_req = lvl;
		data_in      = d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_queue_op(m, lvl, d);
		gap = in_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic report_mismatch(input string what, input queue_result_t want,
			input queue_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t %0s: exp data %h found %b level %0d dropped %b empty %b",
				$realtime, what, want.data, want.found, want.level, want.dropped,
				want.empty);
			$display("    got data %h found %b level %0d dropped %b empty %b",
				got.data, got.found, got.level, got.dropped, got.empty);
		end
	endtask

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		queue_result_t got;
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {data_out, found, served_level, dropped, now_empty};
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		if (stall_left == 0 && !out_quiet)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
		end
	end

	task automatic test_empty_pop();
		send_word(MODE_POP, '1, '1);
		send_word(MODE_POP, '0, '0);
	endtask

	task automatic test_absent_levels();
		send_word(MODE_PUSH, LEVEL_W'(LEVELS), 32'h1234_5678);
		send_word(MODE_PUSH, '1, '1);
		send_word(MODE_PUSH, 4'd10, 32'h8000_0001);
		send_word(MODE_POP, 4'd2, 32'h0);
	endtask

	// Level order across levels, last-in first-out within a level
	task automatic test_level_order();
		send_word(MODE_PUSH, 4'd3, '1);
		send_word(MODE_PUSH, 4'd2, '0);
		send_word(MODE_PUSH, 4'd1, 32'hA5A5_A5A5);
		send_word(MODE_PUSH, 4'd0, 32'h5A5A_5A5A);
		send_word(MODE_PUSH, 4'd0, 32'hFFFF_0000);
		repeat (6) send_word(MODE_POP, LEVEL_W'($urandom), $urandom);
	endtask

	// Fill one level past its depth back to back, then drain it
	task automatic test_full_level();
		in_quiet  = 1'b1;
		out_quiet = 1'b1;
		repeat (LEVEL_DEPTH) send_word(MODE_PUSH, 4'd1, $urandom);
		send_word(MODE_PUSH, 4'd1, $urandom);
		send_word(MODE_PUSH, 4'd3, $urandom);
		in_quiet  = 1'b0;
		out_quiet = 1'b0;
		repeat (LEVEL_DEPTH + 2) send_word(MODE_POP, LEVEL_W'($urandom), $urandom);
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level(input int fav);
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return LEVEL_W'(fav);
		if (r < 88)
			return LEVEL_W'($urandom_range(0, LEVELS - 1));
		return LEVEL_W'($urandom_range(0, 15));
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return $urandom;
	endfunction

	// Phases that fill, drain or mix, so levels run full and empty
	task automatic test_random_traffic(input int n_items);
		int sent;
		int len;
		int kind;
		int push_pct;
		int fav;
		sent = 0;
		while (sent < n_items) begin
			kind      = $urandom_range(0, 2);
			len       = $urandom_range(8, 60);
			push_pct  = (kind == 0) ? 85 : (kind == 1) ? 15 : 50;
			fav       = $urandom_range(0, LEVELS - 1);
			in_quiet  = ($urandom_range(0, 3) == 0);
			out_quiet = ($urandom_range(0, 3) == 0);
			repeat (len) begin
				if ($urandom_range(0, 99) < push_pct)
					send_word(MODE_PUSH, pick_level(fav), pick_data());
				else
					send_word(MODE_POP, LEVEL_W'($urandom), $urandom);
				sent++;
			end
		end
		in_quiet  = 1'b0;
		out_quiet = 1'b0;
	endtask

	initial begin
		foreach (level_count[i])
			level_count[i] = 0;
		words_held = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_pop();
		test_absent_levels();
		test_level_order();
		test_full_level();
		test_random_traffic(600);

		// drop valid and let the last results drain
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("tb_multi_level_lifo_priority_queue_unit passed");
		else
			$display("tb_multi_level_lifo_priority_queue_unit failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5000000;
		$display("tb_multi_level_lifo_priority_queue_unit failed");
		$finish;
	end

endmodule
